>>> rtl/core/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types, constants and helpers of the recent byte cache compressor.
// ----------------------------------------------------------------------------
package rbc_pkg;

  localparam int CACHE_DEPTH = 128;
  localparam int LANES       = 8;
  localparam int LANE_W      = 3;
  localparam int IDX_W       = 7;
  localparam int CELL_W      = IDX_W - LANE_W;

  typedef enum logic [1:0] {
    REG_CACHE_INDEX_BITS = 2'd0,
    REG_LITERAL_BITS     = 2'd1,
    REG_BYPASS           = 2'd2
  } rbc_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_FINISH = 2'd2
  } rbc_state_e;

  typedef struct packed {
    logic             valid;
    logic [7:0]       data;
    logic             found;
    logic [IDX_W-1:0] index;
  } rbc_tok_t;

  typedef struct packed {
    logic             clear;
    logic             wr_en;
    logic [IDX_W-1:0] slot;
    logic [7:0]       data;
  } rbc_cache_cmd_t;

  typedef struct packed {
    logic [7:0]  packed_byte;
    logic        final_res;
    logic [15:0] total_bytes;
    logic        no_gain;
  } rbc_res_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

endpackage

>>> rtl/core/rbc_cell.sv
// ----------------------------------------------------------------------------
// rbc_cell
// One cell of the cache chain: holds up to eight cache entries, checks the
// passing search token against them and hands the token to the next cell.
// ----------------------------------------------------------------------------
module rbc_cell #(
  parameter int CellId   = 0,
  parameter int NumLanes = rbc_pkg::LANES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rbc_pkg::rbc_tok_t      tok_i,
  input  rbc_pkg::rbc_cache_cmd_t cmd_i,
  input  logic [7:0]             entries_i,
  output rbc_pkg::rbc_tok_t      tok_o
);

  localparam int Base = CellId * rbc_pkg::LANES;
  localparam logic [rbc_pkg::CELL_W-1:0] Cid = rbc_pkg::CELL_W'(CellId);

  logic [7:0]        val_q [NumLanes];
  rbc_pkg::rbc_tok_t tok_d, tok_q;
  logic              sel;

  assign sel = cmd_i.wr_en && (cmd_i.slot[rbc_pkg::IDX_W-1:rbc_pkg::LANE_W] == Cid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NumLanes; l++) begin
        val_q[l] <= 8'(Base + l);
      end
    end else if (cmd_i.clear) begin
      for (int l = 0; l < NumLanes; l++) begin
        val_q[l] <= 8'(Base + l);
      end
    end else if (sel) begin
      for (int l = 0; l < NumLanes; l++) begin
        if (cmd_i.slot[rbc_pkg::LANE_W-1:0] == rbc_pkg::LANE_W'(l)) begin
          val_q[l] <= cmd_i.data;
        end
      end
    end
  end

  // lowest matching lane wins
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found) begin
      for (int l = NumLanes - 1; l >= 0; l--) begin
        if ((val_q[l] == tok_i.data) && (8'(Base + l) < entries_i)) begin
          tok_d.found = 1'b1;
          tok_d.index = rbc_pkg::IDX_W'(Base + l);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> rtl/core/rbc_out_buf.sv
// ----------------------------------------------------------------------------
// rbc_out_buf
// Two-entry result queue; loaded with all results of one item at once and
// drained one transaction at a time.
// ----------------------------------------------------------------------------
module rbc_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [1:0]        cnt_i,
  input  rbc_pkg::rbc_res_t res0_i,
  input  rbc_pkg::rbc_res_t res1_i,
  output logic              empty_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rbc_pkg::rbc_res_t res_o
);

  logic [1:0]        cnt_q;
  rbc_pkg::rbc_res_t r0_q, r1_q;
  logic              pop;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign empty_o     = (cnt_q == 2'd0);
  assign out_valid_o = (cnt_q != 2'd0);
  assign res_o       = r0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= cnt_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      r0_q <= res0_i;
      r1_q <= res1_i;
    end else if (pop) begin
      r0_q <= r1_q;
    end
  end

endmodule

>>> rtl/core/recent_byte_cache_compressor.sv
// ----------------------------------------------------------------------------
// recent_byte_cache_compressor
// Codes a byte stream against a cache of recent values (hit: index, miss:
// literal) and packs the code bits MSB first into output bytes (bypass: raw).
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  input   | in_valid_i / in_stall_o    | data_byte_i, end_of_block_i
//  output  | out_valid_o / out_stall_i  | packed_byte_o, final_res_o,
//          |                            | total_bytes_o, no_gain_o
//  config  | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
//  An item is accepted, then its search token walks the cell chain (one
//  register per cell, 8 entries per cell), is picked up at the end of the
//  chain, and the item is coded and packed once the output queue is empty.
//  An item yields zero, one or two transactions.
//  Reset sets cache entry i to i at once; no clearing pass is needed.
//  The input stays stalled from accept until the item's results sit in the
//  output queue; a stalled output holds that queue and the next item waits.
module recent_byte_cache_compressor #(
  parameter int CacheDepth = rbc_pkg::CACHE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_block_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  packed_byte_o,
  output logic        final_res_o,
  output logic [15:0] total_bytes_o,
  output logic        no_gain_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NumCells = (CacheDepth + rbc_pkg::LANES - 1) / rbc_pkg::LANES;
  localparam logic [7:0] Depth8 = 8'(CacheDepth);

  // configuration
  logic [2:0] cfg_k_q;
  logic [3:0] cfg_lit_q;
  logic       cfg_bypass_q;
  rbc_pkg::rbc_reg_e reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = rbc_pkg::rbc_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_k_q      <= 3'd4;
      cfg_lit_q    <= 4'd8;
      cfg_bypass_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        rbc_pkg::REG_CACHE_INDEX_BITS: cfg_k_q      <= pwdata[2:0];
        rbc_pkg::REG_LITERAL_BITS:     cfg_lit_q    <= pwdata[3:0];
        rbc_pkg::REG_BYPASS:           cfg_bypass_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rbc_pkg::REG_CACHE_INDEX_BITS: prdata = {29'd0, cfg_k_q};
      rbc_pkg::REG_LITERAL_BITS:     prdata = {28'd0, cfg_lit_q};
      rbc_pkg::REG_BYPASS:           prdata = {31'd0, cfg_bypass_q};
      default:                       prdata = 32'd0;
    endcase
  end

  // control
  rbc_pkg::rbc_state_e state_q, state_d;
  logic                in_acc, finish, ob_empty;
  rbc_pkg::rbc_tok_t   probe_q;
  rbc_pkg::rbc_tok_t   tok [NumCells+1];
  rbc_pkg::rbc_cache_cmd_t cmd;
  logic [7:0]          byte_q;
  logic                last_q, hit_q;
  logic [rbc_pkg::IDX_W-1:0] idx_q;

  assign in_stall_o = (state_q != rbc_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == rbc_pkg::ST_IDLE);
  assign finish     = (state_q == rbc_pkg::ST_FINISH) && ob_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rbc_pkg::ST_IDLE:   if (in_valid_i) state_d = rbc_pkg::ST_SEARCH;
      rbc_pkg::ST_SEARCH: if (tok[NumCells].valid) state_d = rbc_pkg::ST_FINISH;
      rbc_pkg::ST_FINISH: if (ob_empty) state_d = rbc_pkg::ST_IDLE;
      default:            state_d = rbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q.valid <= in_acc;
      probe_q.data  <= data_byte_i;
      probe_q.found <= 1'b0;
      probe_q.index <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= data_byte_i;
      last_q <= end_of_block_i;
    end
    if (tok[NumCells].valid) begin
      hit_q <= tok[NumCells].found;
      idx_q <= tok[NumCells].index;
    end
  end

  // cell chain
  logic [7:0] pow_w, entries;

  assign pow_w   = 8'd1 << cfg_k_q;
  assign entries = (pow_w > Depth8) ? Depth8 : pow_w;
  assign tok[0]  = probe_q;

  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    localparam int Rem   = CacheDepth - c * rbc_pkg::LANES;
    localparam int Lanes = (Rem < rbc_pkg::LANES) ? Rem : rbc_pkg::LANES;
    rbc_cell #(
      .CellId   (c),
      .NumLanes (Lanes)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok[c]),
      .cmd_i     (cmd),
      .entries_i (entries),
      .tok_o     (tok[c+1])
    );
  end

  // coding and packing
  logic [rbc_pkg::IDX_W-1:0] slot_q, slot_eff;
  logic [6:0]  buf_q;
  logic [2:0]  fill_q, rem;
  logic [15:0] src_cnt_q, out_cnt_q, src_n, oc_a, oc_b;
  logic [3:0]  lit_eff, len;
  logic [7:0]  lit_mask;
  logic [8:0]  code;
  logic [15:0] joined, aligned;
  logic [4:0]  total;
  logic        em0, em1, miss_wr;
  logic [1:0]  res_cnt;
  rbc_pkg::rbc_res_t res0, res1, res_out;

  always_comb begin
    if (cfg_lit_q == 4'd0) begin
      lit_eff = 4'd1;
    end else if (cfg_lit_q > 4'd8) begin
      lit_eff = 4'd8;
    end else begin
      lit_eff = cfg_lit_q;
    end
    lit_mask = 8'((9'd1 << lit_eff) - 9'd1);
    slot_eff = slot_q & rbc_pkg::IDX_W'(pow_w - 8'd1);
    if (hit_q) begin
      code = {2'd0, idx_q};
      len  = 4'd1 + {1'b0, cfg_k_q};
    end else begin
      code = (9'd1 << lit_eff) | {1'b0, byte_q & lit_mask};
      len  = 4'd1 + lit_eff;
    end
    joined  = ({9'd0, buf_q} << len) | {7'd0, code};
    total   = {2'd0, fill_q} + {1'b0, len};
    aligned = joined << (5'd16 - total);
    rem     = total[2:0];

    res0 = '0;
    res1 = '0;
    if (cfg_bypass_q) begin
      em0 = 1'b1;
      em1 = 1'b0;
      res0.packed_byte = byte_q;
    end else begin
      em0 = (total >= 5'd8) || last_q;
      em1 = (total >= 5'd16) || (last_q && (total > 5'd8));
      res0.packed_byte = aligned[15:8];
      res1.packed_byte = aligned[7:0];
    end
    src_n = rbc_pkg::sat_inc(src_cnt_q);
    oc_a  = em0 ? rbc_pkg::sat_inc(out_cnt_q) : out_cnt_q;
    oc_b  = em1 ? rbc_pkg::sat_inc(oc_a) : oc_a;
    if (last_q) begin
      if (em1) begin
        res1.final_res   = 1'b1;
        res1.total_bytes = oc_b;
        res1.no_gain     = !cfg_bypass_q && (oc_b >= src_n);
      end else if (em0) begin
        res0.final_res   = 1'b1;
        res0.total_bytes = oc_b;
        res0.no_gain     = !cfg_bypass_q && (oc_b >= src_n);
      end
    end
    res_cnt = {1'b0, em0} + {1'b0, em1};
    miss_wr = finish && !cfg_bypass_q && !hit_q;

    cmd.clear = finish && last_q;
    cmd.wr_en = miss_wr && !last_q;
    cmd.slot  = slot_eff;
    cmd.data  = byte_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      buf_q     <= '0;
      fill_q    <= '0;
      src_cnt_q <= '0;
      out_cnt_q <= '0;
    end else if (finish) begin
      if (last_q) begin
        slot_q    <= '0;
        buf_q     <= '0;
        fill_q    <= '0;
        src_cnt_q <= '0;
        out_cnt_q <= '0;
      end else begin
        src_cnt_q <= src_n;
        out_cnt_q <= oc_b;
        if (!cfg_bypass_q) begin
          fill_q <= rem;
          buf_q  <= joined[6:0] & 7'((8'd1 << rem) - 8'd1);
          if (!hit_q) begin
            slot_q <= ({1'b0, slot_eff} == entries - 8'd1) ? '0
                      : slot_eff + rbc_pkg::IDX_W'(1);
          end else begin
            slot_q <= slot_eff;
          end
        end
      end
    end
  end

  rbc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (finish),
    .cnt_i       (res_cnt),
    .res0_i      (res0),
    .res1_i      (res1),
    .empty_o     (ob_empty),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign packed_byte_o = res_out.packed_byte;
  assign final_res_o   = res_out.final_res;
  assign total_bytes_o = res_out.total_bytes;
  assign no_gain_o     = res_out.no_gain;

  a_tail_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[NumCells].valid |-> (state_q == rbc_pkg::ST_SEARCH))
    else $error("search token left the chain outside of a search");

  a_block_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && last_q) |=> (fill_q == 3'd0 && src_cnt_q == 16'd0 && slot_q == '0))
    else $error("block state not cleared after end of block");

  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbc_pkg::ST_FINISH && !ob_empty) |=> (state_q == rbc_pkg::ST_FINISH))
    else $error("results dropped while output queue busy");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for recent_byte_cache_compressor. Drives source bytes
// under random idle bursts, predicts the packed output bytes, block totals
// and no-gain flags from its own model of the cache and bit packer, and
// compares every output transaction in order. Register settings are swept
// between phases, with a long output hold and a full drain pause included.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 250;
  localparam int QUIET_LIMIT  = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        end_of_block;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  packed_byte;
  logic        final_res;
  logic [15:0] total_bytes;
  logic        no_gain;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  recent_byte_cache_compressor u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .end_of_block_i (end_of_block),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .packed_byte_o  (packed_byte),
    .final_res_o    (final_res),
    .total_bytes_o  (total_bytes),
    .no_gain_o      (no_gain),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // model of the register file and per-block coder state
  int unsigned idx_bits_m;
  int unsigned lit_bits_m;
  bit          bypass_m;
  logic [7:0]  cache_m [rbc_pkg::CACHE_DEPTH];
  int unsigned slot_m;
  int unsigned pend_bits;
  int unsigned pend_cnt;
  int unsigned src_cnt;
  int unsigned out_cnt;

  rbc_pkg::rbc_res_t item_bytes[$];
  rbc_pkg::rbc_res_t expected_bytes[$];
  rbc_pkg::rbc_res_t exp_res;
  logic [7:0]  recent_bytes [8];
  int unsigned recent_ptr;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          idle_en;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned bump16(input int unsigned v);
    return (v < 65535) ? v + 1 : 65535;
  endfunction

  function automatic void clear_block_model();
    for (int i = 0; i < rbc_pkg::CACHE_DEPTH; i++) begin
      cache_m[i] = i[7:0];
    end
    slot_m    = 0;
    pend_bits = 0;
    pend_cnt  = 0;
    src_cnt   = 0;
    out_cnt   = 0;
  endfunction

  function automatic void emit_byte(input logic [7:0] v);
    rbc_pkg::rbc_res_t r;
    r             = '0;
    r.packed_byte = v;
    item_bytes.push_back(r);
    out_cnt = bump16(out_cnt);
  endfunction

  function automatic void predict_packed_bytes(input logic [7:0] b, input logic eob);
    int unsigned k;
    int unsigned lit;
    int unsigned entries;
    int unsigned code;
    int unsigned len;
    int unsigned idx;
    int unsigned last;
    bit          hit;
    item_bytes.delete();
    src_cnt = bump16(src_cnt);
    if (bypass_m) begin
      emit_byte(b);
    end else begin
      k       = idx_bits_m;
      lit     = (lit_bits_m == 0) ? 1 : (lit_bits_m > 8) ? 8 : lit_bits_m;
      entries = 1 << k;
      if (entries > rbc_pkg::CACHE_DEPTH) entries = rbc_pkg::CACHE_DEPTH;
      if (slot_m >= entries) slot_m = slot_m % entries;
      hit = 1'b0;
      idx = 0;
      for (int i = 0; i < entries; i++) begin
        if (!hit && cache_m[i] == b) begin
          hit = 1'b1;
          idx = i;
        end
      end
      if (hit) begin
        code = idx & ((1 << k) - 1);
        len  = 1 + k;
      end else begin
        code = (1 << lit) | (b & ((1 << lit) - 1));
        len  = 1 + lit;
        cache_m[slot_m] = b;
        slot_m = (slot_m + 1) % entries;
      end
      pend_bits = ((pend_bits << len) | code) & 16'hffff;
      pend_cnt  = pend_cnt + len;
      while (pend_cnt >= 8) begin
        pend_cnt = pend_cnt - 8;
        emit_byte(8'((pend_bits >> pend_cnt) & 8'hff));
      end
      pend_bits = pend_bits & ((1 << pend_cnt) - 1);
      if (eob && pend_cnt > 0) begin
        emit_byte(8'((pend_bits << (8 - pend_cnt)) & 8'hff));
      end
    end
    if (eob) begin
      if (item_bytes.size() > 0) begin
        last = item_bytes.size() - 1;
        item_bytes[last].final_res   = 1'b1;
        item_bytes[last].total_bytes = out_cnt[15:0];
        item_bytes[last].no_gain     = !bypass_m && (out_cnt >= src_cnt);
      end
      clear_block_model();
    end
    foreach (item_bytes[i]) expected_bytes.push_back(item_bytes[i]);
  endfunction

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // output side: compare each accepted transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected output, expected none, actual 0x%0h", $time, packed_byte);
        mismatches++;
      end else begin
        exp_res = expected_bytes.pop_front();
        check_field("packed_byte", exp_res.packed_byte, packed_byte);
        check_field("final_res", exp_res.final_res, final_res);
        check_field("total_bytes", exp_res.total_bytes, total_bytes);
        check_field("no_gain", exp_res.no_gain, no_gain);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver stall: random bursts, or one long hold on request
  initial begin : p_rx_stall
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (idle_en && rst_n && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input rbc_pkg::rbc_reg_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      rbc_pkg::REG_CACHE_INDEX_BITS: idx_bits_m = v[2:0];
      rbc_pkg::REG_LITERAL_BITS:     lit_bits_m = v[3:0];
      rbc_pkg::REG_BYPASS:           bypass_m   = v[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned k, input int unsigned lit, input bit byp);
    write_reg(rbc_pkg::REG_CACHE_INDEX_BITS, k);
    write_reg(rbc_pkg::REG_LITERAL_BITS, lit);
    write_reg(rbc_pkg::REG_BYPASS, byp);
  endtask

  // valid stays high into the next call; gaps lower it for a burst first
  task automatic send_item(input logic [7:0] b, input logic eob);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    end_of_block <= eob;
    do @(posedge clk); while (in_stall);
    predict_packed_bytes(b, eob);
    recent_bytes[recent_ptr] = b;
    recent_ptr = (recent_ptr + 1) % 8;
  endtask

  task automatic send_random_item(input int unsigned eob_rate);
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0:       b = $urandom_range(0, 255);
      1:       b = $urandom_range(0, 15);
      default: b = recent_bytes[$urandom_range(0, 7)];
    endcase
    send_item(b, $urandom_range(0, eob_rate) == 0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_default_coding();
    send_item(8'd0, 1'b0);
    send_item(8'd15, 1'b0);
    send_item(8'd16, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd16, 1'b1);
    send_item(8'h42, 1'b1);
    wait_drained();
  endtask

  task automatic test_literal_width();
    write_reg(rbc_pkg::REG_LITERAL_BITS, 0);
    send_item(8'd3, 1'b0);
    send_item(8'd2, 1'b1);
    wait_drained();
    write_reg(rbc_pkg::REG_LITERAL_BITS, 15);
    send_item(8'hab, 1'b1);
    wait_drained();
    write_reg(rbc_pkg::REG_LITERAL_BITS, 8);
  endtask

  task automatic test_index_width();
    write_reg(rbc_pkg::REG_CACHE_INDEX_BITS, 0);
    send_item(8'd0, 1'b0);
    send_item(8'd1, 1'b0);
    send_item(8'd1, 1'b1);
    wait_drained();
    write_reg(rbc_pkg::REG_CACHE_INDEX_BITS, 7);
    send_item(8'd127, 1'b0);
    send_item(8'd128, 1'b0);
    send_item(8'd128, 1'b1);
    wait_drained();
  endtask

  // index width shrinks inside a block, so the fifo slot wraps
  task automatic test_slot_wrap();
    write_reg(rbc_pkg::REG_CACHE_INDEX_BITS, 3);
    send_item(8'd100, 1'b0);
    send_item(8'd101, 1'b0);
    send_item(8'd102, 1'b0);
    wait_drained();
    write_reg(rbc_pkg::REG_CACHE_INDEX_BITS, 1);
    send_item(8'd103, 1'b0);
    send_item(8'd103, 1'b1);
    wait_drained();
    write_reg(rbc_pkg::REG_CACHE_INDEX_BITS, 4);
  endtask

  // bypass entered mid-block drops the pending code bits
  task automatic test_bypass();
    send_item(8'd200, 1'b0);
    wait_drained();
    write_reg(rbc_pkg::REG_BYPASS, 1);
    send_item(8'h5a, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b1);
    wait_drained();
    write_reg(rbc_pkg::REG_BYPASS, 0);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (40) send_random_item(12);
    wait_drained();
    repeat (6) send_random_item(1000);
    wait_drained();
    repeat (10) send_random_item(8);
    wait_drained();
  endtask

  task automatic test_random_phases(input int phases, input int per_phase);
    int unsigned k;
    int unsigned lit;
    int unsigned eob_rate;
    for (int p = 0; p < phases; p++) begin
      k        = (p == 0) ? 0 : (p == 1) ? 7 : $urandom_range(0, 7);
      lit      = (p == 0) ? 1 : (p == 1) ? 8 : (p == 2) ? 0 : (p == 3) ? 15
                 : $urandom_range(0, 15);
      eob_rate = (p % 3 == 0) ? $urandom_range(1, 4) : $urandom_range(8, 40);
      set_config(k, lit, (p > 1) && ($urandom_range(0, 4) == 0));
      idle_en = (p != 4);
      for (int i = 0; i < per_phase; i++) send_random_item(eob_rate);
      wait_drained();
    end
    idle_en = 1'b1;
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    set_config(4, 8, 0);
    repeat (200) send_random_item(20);
    send_item(8'h00, 1'b1);
    wait_drained();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    data_byte    <= 8'h00;
    end_of_block <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    idx_bits_m   = 4;
    lit_bits_m   = 8;
    bypass_m     = 1'b0;
    mismatches   = 0;
    recent_ptr   = 0;
    hold_req     = 1'b0;
    idle_en      = 1'b1;
    foreach (recent_bytes[i]) recent_bytes[i] = 8'(i);
    clear_block_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_coding();
    test_literal_width();
    test_index_width();
    test_slot_wrap();
    test_bypass();
    test_backpressure();
    test_random_phases(8, 150);
    test_no_idle();

    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
